@@ rtl/msdl_pkg.sv @@
// msdl_pkg: types and constants shared by the motor speed drive loop.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msdl_pkg;

    // Widths fixed by the sample and result formats
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 2;
    localparam int DIV_W   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] SPEED_MAX = 8'd255;

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_SPEED_CONSTANT = 2'd0;
    localparam logic [1:0] REG_LOOP_GAIN      = 2'd1;
    localparam logic [1:0] REG_DRIVE_LIMIT    = 2'd2;

    localparam logic [15:0] SPEED_CONSTANT_RST = 16'd12754;
    localparam logic [7:0]  LOOP_GAIN_RST      = 8'd20;
    localparam logic [7:0]  DRIVE_LIMIT_RST    = 8'd127;

    typedef struct packed {
        logic [IDX_W-1:0]  motor_index;
        logic [BYTE_W-1:0] period_low_byte;
        logic [BYTE_W-1:0] period_high_byte;
        logic [BYTE_W-1:0] target_speed;
    } sample_t;

    typedef struct packed {
        logic [BYTE_W-1:0] measured_speed;
        logic              speed_updated;
        logic              drive_issued;
        logic              drive_forward;
        logic [BYTE_W-1:0] drive_magnitude;
    } result_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [IDX_W-1:0]  motor_index;
        logic              in_range;
        logic              changed;
        logic [DIV_W-1:0]  period;
        logic [BYTE_W-1:0] target_speed;
    } cmd_t;

    typedef struct packed {
        logic [15:0] speed_constant;
        logic [7:0]  loop_gain;
        logic [7:0]  drive_limit;
    } cfg_t;

endpackage

@@ rtl/motor_speed_drive_loop.sv @@
// motor_speed_drive_loop: top level; register port, front end, queue, back end.
// Depends on msdl_pkg, msdl_front, msdl_fifo, msdl_back.
`timescale 1ns / 1ps

// Speed loop for up to MOTOR_COUNT motors. Each sample names a motor, carries
// its period counter bytes and target speed, and yields exactly one result.
// The front end takes a sample and parks it in a two-entry queue; with results
// not being taken, two samples wait in the queue, one is held in the back end
// and one result sits in the output register, so four samples are absorbed
// before full rises. The back end works one sample at a time: a sample whose
// period bytes changed goes from the queue pop through the 16-step restoring
// divider and a multiply, then a clamp and drive only if the speed changed,
// and ends in the output hand-over; a zero period skips the divider, and a
// sample with unchanged bytes or a motor number out of range goes straight
// to the output hand-over.
// Registers: speed_constant at 0x0, loop_gain at 0x4, drive_limit at 0x8.
module motor_speed_drive_loop #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msdl_pkg::sample_t sample,
    input  logic              push,
    output logic              full,
    output msdl_pkg::result_t result,
    output logic              empty,
    input  logic              pop,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import msdl_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       front_cmd, q_head;
    logic       accept, q_empty, q_pop;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign accept  = push && !full;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_constant <= SPEED_CONSTANT_RST;
            cfg_reg.loop_gain      <= LOOP_GAIN_RST;
            cfg_reg.drive_limit    <= DRIVE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SPEED_CONSTANT: cfg_reg.speed_constant <= pwdata[15:0];
                REG_LOOP_GAIN:      cfg_reg.loop_gain      <= pwdata[7:0];
                REG_DRIVE_LIMIT:    cfg_reg.drive_limit    <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        case (reg_idx)
            REG_SPEED_CONSTANT: prdata = {16'd0, cfg_reg.speed_constant};
            REG_LOOP_GAIN:      prdata = {24'd0, cfg_reg.loop_gain};
            REG_DRIVE_LIMIT:    prdata = {24'd0, cfg_reg.drive_limit};
            default:            prdata = '0;
        endcase
    end

    msdl_front #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .accept (accept),
        .cmd    (front_cmd)
    );

    msdl_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (full),
        .empty   (q_empty)
    );

    msdl_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

@@ rtl/msdl_fifo.sv @@
// msdl_fifo: short first-word-fall-through queue of classified samples.
// Depends on msdl_pkg (cmd_t, QUEUE_DEPTH).
`timescale 1ns / 1ps

module msdl_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  msdl_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output msdl_pkg::cmd_t rd_data,
    output logic           full,
    output logic           empty
);
    import msdl_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/msdl_front.sv @@
// msdl_front: accepts samples, keeps the last period bytes per motor and
// classifies each sample for the back end. Depends on msdl_pkg.
`timescale 1ns / 1ps

module msdl_front #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msdl_pkg::sample_t sample,
    input  logic              accept,
    output msdl_pkg::cmd_t    cmd
);
    import msdl_pkg::*;

    logic [BYTE_W-1:0] low_reg  [MOTOR_COUNT];
    logic [BYTE_W-1:0] high_reg [MOTOR_COUNT];
    logic [BYTE_W-1:0] low_sel, high_sel;
    logic              in_range;

    assign in_range = int'(sample.motor_index) < MOTOR_COUNT;

    // Look up the stored bytes of the addressed motor
    always_comb
    begin
        low_sel  = '0;
        high_sel = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            if (i == int'(sample.motor_index))
            begin
                low_sel  = low_reg[i];
                high_sel = high_reg[i];
            end
        end
    end

    // Classification
    always_comb
    begin
        cmd.motor_index  = sample.motor_index;
        cmd.in_range     = in_range;
        cmd.changed      = in_range && ((sample.period_low_byte != low_sel) ||
                                        (sample.period_high_byte != high_sel));
        cmd.period       = {sample.period_high_byte, sample.period_low_byte};
        cmd.target_speed = sample.target_speed;
    end

    // Per-motor byte store, updated on a transfer with changed bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
        end
        else if (accept && cmd.changed)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                if (i == int'(sample.motor_index))
                begin
                    low_reg[i]  <= sample.period_low_byte;
                    high_reg[i] <= sample.period_high_byte;
                end
            end
        end
    end

endmodule

@@ rtl/msdl_div.sv @@
// msdl_div: restoring divider, one quotient bit per cycle.
// Depends on msdl_pkg (DIV_W).
`timescale 1ns / 1ps

module msdl_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [msdl_pkg::DIV_W-1:0] dividend,
    input  logic [msdl_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [msdl_pkg::DIV_W-1:0] quotient
);
    import msdl_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   trial;

    assign done     = done_reg;
    assign quotient = quot_reg;

    // One trial subtraction per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[DIV_W-1]};
        trial     = rem_sh - {1'b0, dsr_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DIV_W])
            begin
                rem_next  = trial[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

endmodule

@@ rtl/msdl_back.sv @@
// msdl_back: takes classified samples from the queue, derives speed with the
// divider, computes the drive command and holds the result for transfer.
// Depends on msdl_pkg and msdl_div.
`timescale 1ns / 1ps

module msdl_back #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msdl_pkg::cfg_t    cfg,
    input  msdl_pkg::cmd_t    q_head,
    input  logic              q_empty,
    output logic              q_pop,
    output msdl_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);
    import msdl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_CMD  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [BYTE_W-1:0] old_reg, new_reg, new_next;
    logic signed [19:0] prod_reg;
    result_t           res_reg, res_next;
    result_t           out_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] speed_reg [MOTOR_COUNT];
    logic [BYTE_W-1:0] old_sel;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  quotient;
    logic signed [10:0] diff;
    logic signed [19:0] lim, clamped, cmd_sum;
    logic [19:0]       cmd_abs;

    assign result = out_reg;
    assign empty  = !out_valid_reg;
    assign q_pop  = (state_reg == S_IDLE) && !q_empty;

    // Held speed of the motor at the queue head
    always_comb
    begin
        old_sel = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            if (i == int'(q_head.motor_index))
            begin
                old_sel = speed_reg[i];
            end
        end
    end

    assign div_start = q_pop && q_head.changed && (q_head.period != '0);

    msdl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.speed_constant),
        .divisor  (q_head.period),
        .done     (div_done),
        .quotient (quotient)
    );

    // Error term: 2*target - speed
    assign diff = $signed({2'b00, cmd_reg.target_speed, 1'b0}) -
                  $signed({3'b000, new_reg});

    // Clamp, add target, split into direction and magnitude
    always_comb
    begin
        lim = $signed({12'd0, cfg.drive_limit});
        if (prod_reg > lim)
        begin
            clamped = lim;
        end
        else if (prod_reg < -lim)
        begin
            clamped = -lim;
        end
        else
        begin
            clamped = prod_reg;
        end
        cmd_sum = clamped + $signed({12'd0, cmd_reg.target_speed});
        cmd_abs = cmd_sum[19] ? 20'(-cmd_sum) : 20'(cmd_sum);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !pop;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    res_next = '0;
                    if (!q_head.in_range)
                    begin
                        state_next = S_DONE;
                    end
                    else if (!q_head.changed)
                    begin
                        res_next.measured_speed = old_sel;
                        state_next = S_DONE;
                    end
                    else if (q_head.period == '0)
                    begin
                        new_next   = SPEED_MAX;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    new_next   = (quotient > DIV_W'(SPEED_MAX)) ? SPEED_MAX
                                                                : quotient[BYTE_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                res_next.measured_speed = new_reg;
                res_next.speed_updated  = 1'b1;
                state_next = (new_reg != old_reg) ? S_CMD : S_DONE;
            end
            S_CMD:
            begin
                res_next.drive_issued    = 1'b1;
                res_next.drive_forward   = !cmd_sum[19];
                res_next.drive_magnitude = (cmd_abs > 20'(SPEED_MAX)) ? SPEED_MAX
                                                                      : cmd_abs[BYTE_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                speed_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // Speed store follows the recomputed speed
            if (state_reg == S_MUL)
            begin
                for (int i = 0; i < MOTOR_COUNT; i++)
                begin
                    if (i == int'(cmd_reg.motor_index))
                    begin
                        speed_reg[i] <= new_reg;
                    end
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        res_reg <= res_next;
        if (q_pop)
        begin
            cmd_reg <= q_head;
            old_reg <= old_sel;
        end
        if (state_reg == S_MUL)
        begin
            // Both operands widened to the product width before the multiply
            prod_reg <= 20'(diff) * 20'($signed({1'b0, cfg.loop_gain}));
        end
        if (state_reg == S_DONE && (!out_valid_reg || pop))
        begin
            out_reg <= res_reg;
        end
    end

endmodule

@@ rtl/msdl_checker.sv @@
// msdl_checker: port-level checks on the speed loop, bound to the top level.
// Depends on msdl_pkg and motor_speed_drive_loop.
`timescale 1ns / 1ps

module msdl_checker (
    input logic              clk,
    input logic              rst_n,
    input msdl_pkg::result_t result,
    input logic              empty,
    input logic              pop,
    input logic              pready
);
    import msdl_pkg::*;

    // Nothing waits on the result side straight after reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown after reset");

    // A result with no drive carries neither direction nor magnitude
    a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.drive_issued) |->
        (!result.drive_forward && result.drive_magnitude == '0))
        else $error("drive fields set without a drive");

    // A drive is only given when the speed was recomputed
    a_drive_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.drive_issued) |-> result.speed_updated)
        else $error("drive without a speed update");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

    // The register port never inserts wait states
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind motor_speed_drive_loop msdl_checker u_msdl_checker (.*);
